### design/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants of the lru key/value cache
// entry layout, action codes and defaults used by the cell row and the top
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lkv_pkg;

  // field widths
  localparam int KeyW = 32;
  localparam int ValW = 32;
  localparam int CapW = 5;

  // defaults
  localparam int            MaxEntriesDef = 16;
  localparam logic [CapW-1:0] CapReset    = 5'd16;

  // value returned by a get that misses
  localparam logic [ValW-1:0] ReadMiss = '1;

  // action codes
  typedef enum logic [0:0] {
    ActGet = 1'b0,
    ActSet = 1'b1
  } action_e;

  // one stored entry
  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } entry_t;

endpackage : lkv_pkg

`default_nettype wire

### design/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key/value cache with lru replacement
// entries sit in a row of cells ordered by recency, newest at the head
// ----------------------------------------------------------------------------
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+----------------------------
//  s_axis    | in        | s_axis_tvalid/tready   | tuser: action; tdata: key,value
//  m_axis    | out       | m_axis_tvalid/tready   | tuser: hit,evicted;
//            |           |                        | tdata: read_value,evicted_key
//  cfg       | in        | cfg_valid_i/cfg_ready_o| capacity
//
//  one item a cycle while the output is not stalled: the probe key is compared
//  with all cells at once and the row shifts in that same cycle; the result is
//  registered. the depth of the match chain and the or of values over the cells
//  set the critical path. a capacity write clears all valid flags.
//  reset empties the cache and sets the capacity to 16. a stalled output
//  holds its item; a new item is taken in the cycle the held one leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache
  import lkv_pkg::*;
#(
  parameter int MAX_ENTRIES = MaxEntriesDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // input items
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [63:0]      s_axis_tdata,   // [31:0] key, [63:32] value
  input  wire logic [0:0]       s_axis_tuser,   // [0] action
  // result items
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [63:0]           m_axis_tdata,   // [31:0] read_value, [63:32] evicted_key
  output logic [1:0]            m_axis_tuser,   // [0] hit, [1] evicted
  // capacity register
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CapW-1:0]  cfg_data_i
);

  localparam int CntW = $clog2(MAX_ENTRIES + 1);
  localparam int CmpW = (CntW > CapW) ? CntW : CapW;

  // registers
  logic [CapW-1:0]  cap_q;
  logic [CntW-1:0]  used_q, used_d;
  logic             out_valid_q, out_valid_d;
  logic             out_hit_q, out_evicted_q;
  logic [ValW-1:0]  out_rdata_q;
  logic [KeyW-1:0]  out_ekey_q;

  // item fields
  action_e          act;
  logic [KeyW-1:0]  in_key;
  logic [ValW-1:0]  in_value;
  logic             in_acc, cfg_acc;

  // row wiring
  entry_t               row_w   [MAX_ENTRIES+1];  // row_w[j] feeds cell j
  logic [MAX_ENTRIES:0] chain_w;                 // chain_w[j]: match at j or right
  logic [MAX_ENTRIES:0] valid_w;                 // valid_w[j]: cell j valid
  logic [MAX_ENTRIES-1:0] match, shift, last;

  // lookup results
  logic             hit, is_set, full, evict;
  logic [ValW-1:0]  hit_value, rdata;
  logic [KeyW-1:0]  ev_key;
  logic [CmpW-1:0]  cap_ext, eff_cap;

  assign act      = action_e'(s_axis_tuser[0]);
  assign in_key   = s_axis_tdata[KeyW-1:0];
  assign in_value = s_axis_tdata[KeyW+ValW-1:KeyW];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_acc       = cfg_valid_i;

  // effective capacity, clamped to 1 .. MAX_ENTRIES
  assign cap_ext = CmpW'(cap_q);
  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CmpW'(1);
    end else if (cap_ext > CmpW'(MAX_ENTRIES)) begin
      eff_cap = CmpW'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full   = CmpW'(used_q) >= eff_cap;
  assign hit    = chain_w[0];
  assign is_set = (act == ActSet);
  assign evict  = is_set && !hit && full;

  // ends of the chains
  assign chain_w[MAX_ENTRIES] = 1'b0;
  assign valid_w[MAX_ENTRIES] = 1'b0;

  // value of the hit cell and key of the oldest cell
  always_comb begin
    hit_value = '0;
    ev_key    = '0;
    for (int j = 0; j < MAX_ENTRIES; j++) begin
      last[j] = valid_w[j] && !valid_w[j+1];
      if (match[j]) begin
        hit_value = hit_value | row_w[j+1].value;
      end
      if (last[j]) begin
        ev_key = ev_key | row_w[j+1].key;
      end
    end
  end

  // new head entry
  assign row_w[0] = '{valid: 1'b1, key: in_key, value: (is_set ? in_value : hit_value)};

  // which cells shift: up to the hit, or up to the insert point
  always_comb begin
    for (int j = 0; j < MAX_ENTRIES; j++) begin
      if (!in_acc) begin
        shift[j] = 1'b0;
      end else if (hit) begin
        shift[j] = chain_w[j];
      end else if (is_set) begin
        shift[j] = full ? valid_w[j] : (valid_w[j] || row_w[j].valid);
      end else begin
        shift[j] = 1'b0;
      end
    end
  end

  // the cell row
  for (genvar j = 0; j < MAX_ENTRIES; j++) begin : g_cell
    lkv_cell u_cell (
      .clk_i              (clk_i),
      .rst_ni             (rst_ni),
      .clear_i            (cfg_acc),
      .shift_i            (shift[j]),
      .entry_i            (row_w[j]),
      .key_i              (in_key),
      .match_right_i      (chain_w[j+1]),
      .entry_o            (row_w[j+1]),
      .match_o            (match[j]),
      .match_here_right_o (chain_w[j])
    );
    assign valid_w[j] = row_w[j+1].valid;
  end

  // fill count
  always_comb begin
    used_d = used_q;
    if (cfg_acc) begin
      used_d = '0;
    end else if (in_acc && is_set && !hit && !full) begin
      used_d = used_q + CntW'(1);
    end
  end

  // read data of the result
  always_comb begin
    if (is_set) begin
      rdata = '0;
    end else if (hit) begin
      rdata = hit_value;
    end else begin
      rdata = ReadMiss;
    end
  end

  // output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapReset;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_acc) begin
        cap_q <= cfg_data_i;
      end
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_hit_q     <= hit;
      out_evicted_q <= evict;
      out_rdata_q   <= rdata;
      out_ekey_q    <= evict ? ev_key : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_ekey_q, out_rdata_q};
  assign m_axis_tuser  = {out_evicted_q, out_hit_q};

  // fill count agrees with the valid flags of the row
  a_used_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_w) == int'(used_q))
    else $error("fill count differs from number of valid cells");

  // valid cells are packed at the head of the row
  a_packed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_w[MAX_ENTRIES-1:0] + MAX_ENTRIES'(1)) & valid_w[MAX_ENTRIES-1:0]) == '0)
    else $error("gap in the row of valid cells");

  // never more entries than the effective capacity
  a_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_acc |=> CmpW'(used_q) <= eff_cap || $past(cfg_acc))
    else $error("fill count above capacity");

  // an accepted set leaves a valid head entry holding its key
  a_set_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_set && !cfg_acc |=> row_w[1].valid && row_w[1].key == $past(in_key))
    else $error("set item not at the head of the row");

endmodule : lru_key_value_cache

`default_nettype wire

### design/lkv_cell.sv
// ----------------------------------------------------------------------------
// lkv_cell: one place of the recency-ordered entry row
// holds one entry, compares it with the probe key and loads its left
// neighbour's entry when the row shifts through it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lkv_cell
  import lkv_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            clear_i,        // empty the cell
  input  wire logic            shift_i,        // take the left neighbour's entry
  input  wire entry_t          entry_i,        // left neighbour (newer side)
  input  wire logic [KeyW-1:0] key_i,          // probe key
  input  wire logic            match_right_i,  // a match lies further right
  output entry_t               entry_o,
  output logic                 match_o,
  output logic                 match_here_right_o
);

  logic            valid_q, valid_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [ValW-1:0] value_q, value_d;

  // next entry
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    if (clear_i) begin
      valid_d = 1'b0;
    end else if (shift_i) begin
      valid_d = entry_i.valid;
      key_d   = entry_i.key;
      value_d = entry_i.value;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // key and value payload
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  // compare and pass the match on towards the head
  assign match_o            = valid_q && (key_q == key_i);
  assign match_here_right_o = match_o || match_right_i;

  assign entry_o = '{valid: valid_q, key: key_q, value: value_q};

endmodule : lkv_cell

`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the lru key/value cache
// drives get/set accesses on the input stream, predicts every response with a
// behavioural copy of the cache in the bench, and compares each response field
// by field; the capacity register is swept over its extremes between phases
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import lkv_pkg::*;

  localparam int Entries = MaxEntriesDef;

  // one predicted response
  typedef struct packed {
    logic            hit;
    logic [ValW-1:0] read_value;
    logic            evicted;
    logic [KeyW-1:0] evicted_key;
  } response_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // block ports
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [63:0]     s_axis_tdata  = '0;   // [31:0] key, [63:32] value
  logic [0:0]      s_axis_tuser  = '0;   // [0] action
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b1;
  logic [63:0]     m_axis_tdata;         // [31:0] read_value, [63:32] evicted_key
  logic [1:0]      m_axis_tuser;         // [0] hit, [1] evicted
  logic            cfg_valid_i   = 1'b0;
  logic            cfg_ready_o;
  logic [CapW-1:0] cfg_data_i    = '0;

  // bench copy of the cache contents
  logic [KeyW-1:0] cache_key   [Entries];
  logic [ValW-1:0] cache_value [Entries];
  bit              cache_valid [Entries];
  int unsigned     cache_rank  [Entries];
  int unsigned     cache_used;
  logic [CapW-1:0] cache_capacity = CapReset;

  response_t due_responses[$];
  int        mismatches = 0;

  // pacing of both sides
  bit          sender_idles = 1'b1;
  bit          stall_on     = 1'b1;
  int          burst_left   = 0;
  logic [31:0] ready_pattern = 32'h1;
  int          ready_age     = 0;

  lru_key_value_cache #(
    .MAX_ENTRIES (Entries)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // cache behaviour in the bench
  // ---------------------------------------------------------------------------

  function automatic void empty_cache();
    for (int i = 0; i < Entries; i++) begin
      cache_key[i]   = '0;
      cache_value[i] = '0;
      cache_valid[i] = 1'b0;
      cache_rank[i]  = 0;
    end
    cache_used = 0;
  endfunction

  // make a slot the most recent, newer entries age by one
  function automatic void promote(int slot);
    int unsigned r;
    r = cache_rank[slot];
    for (int i = 0; i < Entries; i++)
      if (cache_valid[i] && cache_rank[i] < r) cache_rank[i]++;
    cache_rank[slot] = 0;
  endfunction

  function automatic response_t apply_access(action_e act, logic [KeyW-1:0] key,
                                             logic [ValW-1:0] val);
    response_t   r;
    bit          found;
    bit          have_slot;
    int          slot;
    int unsigned oldest;
    int unsigned usable;
    r     = '0;
    found = 1'b0;
    slot  = 0;
    for (int i = 0; i < Entries; i++)
      if (!found && cache_valid[i] && cache_key[i] == key) begin
        found = 1'b1;
        slot  = i;
      end
    if (act == ActGet) begin
      if (found) begin
        r.hit        = 1'b1;
        r.read_value = cache_value[slot];
        promote(slot);
      end else begin
        r.read_value = ReadMiss;
      end
    end else if (found) begin
      r.hit             = 1'b1;
      cache_value[slot] = val;
      promote(slot);
    end else begin
      // capacity 0 behaves as 1, anything above the store size as full size
      usable = (cache_capacity == 0) ? 1 :
               (cache_capacity > Entries) ? Entries : cache_capacity;
      have_slot = 1'b0;
      oldest    = 0;
      if (cache_used >= usable) begin
        for (int i = 0; i < Entries; i++)
          if (cache_valid[i] && (!have_slot || cache_rank[i] > oldest)) begin
            have_slot = 1'b1;
            oldest    = cache_rank[i];
            slot      = i;
          end
        if (have_slot) begin
          r.evicted         = 1'b1;
          r.evicted_key     = cache_key[slot];
          cache_valid[slot] = 1'b0;
          cache_used--;
        end
      end
      // lowest free slot takes the new entry
      have_slot = 1'b0;
      for (int i = 0; i < Entries; i++)
        if (!have_slot && !cache_valid[i]) begin
          have_slot = 1'b1;
          slot      = i;
        end
      if (have_slot) begin
        for (int i = 0; i < Entries; i++)
          if (cache_valid[i]) cache_rank[i]++;
        cache_key[slot]   = key;
        cache_value[slot] = val;
        cache_valid[slot] = 1'b1;
        cache_rank[slot]  = 0;
        cache_used++;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // port watcher: predicts on each accepted item, checks each response
  // ---------------------------------------------------------------------------

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : watch_ports
    response_t exp_r;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_responses.size() == 0) begin
          $display("%0t: response with none awaited, expected nothing, actual %h/%h",
                   $time, m_axis_tuser, m_axis_tdata);
          mismatches++;
        end else begin
          exp_r = due_responses.pop_front();
          compare_field("hit", 32'(exp_r.hit), 32'(m_axis_tuser[0]));
          compare_field("read_value", exp_r.read_value, m_axis_tdata[31:0]);
          compare_field("evicted", 32'(exp_r.evicted), 32'(m_axis_tuser[1]));
          compare_field("evicted_key", exp_r.evicted_key, m_axis_tdata[63:32]);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cache_capacity = cfg_data_i;
        empty_cache();
      end
      if (s_axis_tvalid && s_axis_tready)
        due_responses.push_back(apply_access(action_e'(s_axis_tuser[0]),
                                             s_axis_tdata[31:0], s_axis_tdata[63:32]));
    end
  end

  // receiver stalls on a rotating random pattern, renewed now and then
  always @(posedge clk_i) begin
    if (ready_age == 0) ready_pattern = $urandom() | 32'h1;
    ready_age     = (ready_age + 1) % 48;
    ready_pattern = {ready_pattern[30:0], ready_pattern[31]};
    m_axis_tready <= stall_on ? ready_pattern[0] : 1'b1;
  end

  // ---------------------------------------------------------------------------
  // driving tasks
  // ---------------------------------------------------------------------------

  // one access; valid stays high into the next one unless a gap is taken
  task automatic send_access(action_e act, logic [KeyW-1:0] key, logic [ValW-1:0] val);
    int gap;
    if (sender_idles) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(0, 6);
        burst_left = $urandom_range(1, 12);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {val, key};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop sending and wait for every awaited response
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (due_responses.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CapW-1:0] cap);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes, hits and misses at the reset capacity
  task automatic test_basic_access();
    send_access(ActGet, 32'h0000_0000, 32'h0000_0000);   // get on an empty cache
    send_access(ActSet, 32'h8000_0000, 32'h7FFF_FFFF);
    send_access(ActSet, 32'h7FFF_FFFF, 32'h8000_0000);
    send_access(ActSet, 32'h0000_0000, 32'h0000_0000);
    send_access(ActSet, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_access(ActGet, 32'h8000_0000, 32'h1234_5678);
    send_access(ActGet, 32'hFFFF_FFFF, 32'h0000_0000);   // hit that reads all ones
    send_access(ActSet, 32'h7FFF_FFFF, 32'h1234_5678);   // overwrite on hit
    send_access(ActGet, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_access(ActGet, 32'h0000_0001, 32'h0000_0000);   // miss, state unchanged
    wait_drain();
  endtask

  // capacity zero acts as one: every new key evicts the previous one
  task automatic test_capacity_zero();
    write_capacity(5'd0);
    send_access(ActSet, 32'h0000_0005, 32'hAAAA_5555);
    send_access(ActSet, 32'h0000_0006, 32'h5555_AAAA);
    send_access(ActGet, 32'h0000_0005, 32'h0000_0000);
    send_access(ActGet, 32'h0000_0006, 32'h0000_0000);
    send_access(ActSet, 32'h0000_0006, 32'h0F0F_0F0F);
    wait_drain();
  endtask

  // a get refreshes recency, so the next set miss evicts the next oldest
  task automatic test_lru_order();
    write_capacity(5'd3);
    send_access(ActSet, 32'hA000_0001, 32'h0000_0011);
    send_access(ActSet, 32'hB000_0002, 32'h0000_0022);
    send_access(ActSet, 32'hC000_0003, 32'h0000_0033);
    send_access(ActGet, 32'hA000_0001, 32'h0000_0000);
    send_access(ActSet, 32'hD000_0004, 32'h0000_0044);
    send_access(ActSet, 32'hE000_0005, 32'h0000_0055);
    send_access(ActGet, 32'hB000_0002, 32'h0000_0000);
    send_access(ActGet, 32'hA000_0001, 32'h0000_0000);
    wait_drain();
  endtask

  // random traffic over a small key pool per capacity setting
  task automatic test_random_traffic();
    logic [CapW-1:0] caps[10];
    logic [KeyW-1:0] key_pool[$];
    logic [KeyW-1:0] key;
    int              usable;
    int              pool_size;
    caps = '{5'd16, 5'd1, 5'd31, 5'd2, 5'd4, 5'd0, 5'd8, 5'd5, 5'd16, 5'd3};
    caps[9] = $urandom_range(0, 31);
    for (int phase = 0; phase < 10; phase++) begin
      sender_idles = (phase % 3 != 0);
      stall_on     = (phase % 4 != 1);
      write_capacity(caps[phase]);
      usable = (caps[phase] == 0) ? 1 : (caps[phase] > Entries) ? Entries : caps[phase];
      pool_size = usable + $urandom_range(1, 4);
      key_pool.delete();
      for (int k = 0; k < pool_size; k++) key_pool.push_back($urandom());
      for (int n = 0; n < 75; n++) begin
        // mostly pool keys so hits and evictions happen, some fresh keys
        if ($urandom_range(0, 9) == 0) key = $urandom();
        else key = key_pool[$urandom_range(0, pool_size - 1)];
        send_access(action_e'($urandom_range(0, 1)), key, $urandom());
        // sender holds off mid-phase until all responses are back
        if (n == 37) wait_drain();
      end
      wait_drain();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    empty_cache();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_access();
    test_capacity_zero();
    test_lru_order();
    test_random_traffic();
    wait_drain();
    if (mismatches == 0 && due_responses.size() == 0) begin
      $display("lru_key_value_cache verification clean");
    end else begin
      $display("lru_key_value_cache verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("lru_key_value_cache verification failed");
    $finish;
  end

endmodule
